>>> hdl/book_cipher_position_decoder_macros.svh
// assertion macros for the book cipher position decoder
// no dependencies; taken in by the modules that carry assertions
`ifndef BOOK_CIPHER_POSITION_DECODER_MACROS_SVH
`define BOOK_CIPHER_POSITION_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define BCPD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("bcpd invariant violated");
`define BCPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcpd implication violated");
`define BCPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcpd next-cycle check violated");
`else
`define BCPD_ASSERT_ALWAYS(label, clk, rst, cond)
`define BCPD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BCPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/bcpd_pkg.sv
// shared types and constants of the book cipher position decoder
// no dependencies
package bcpd_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 8;
   localparam int ACC_W       = 16;
   localparam int KEY_WORDS_W = 13;
   // index and address widths wide enough for the whole range of the sizing parameters
   localparam int IDX_MAX_W   = 16;
   localparam int ADDR_MAX_W  = 20;

   localparam logic [ACC_W-1:0] ACC_MAX = 16'hFFFF;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_KEY    = 2'd1;
   localparam logic [1:0] REQ_CIPHER = 2'd2;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;

   // one classified item: key store writes, an optional lookup and up to three results
   typedef struct packed {
      logic                   wr_start;
      logic                   wr_len;
      logic [IDX_MAX_W-1:0]   wr_idx;
      logic [ADDR_MAX_W-1:0]  start_val;
      logic [LEN_W-1:0]       len_val;
      logic                   wr_char;
      logic [ADDR_MAX_W-1:0]  char_addr;
      logic [BYTE_W-1:0]      char_val;
      logic                   lookup;
      logic                   in_range;
      logic [ACC_W-1:0]       word_idx;
      logic [ACC_W-1:0]       char_idx;
      logic                   echo;
      logic [BYTE_W-1:0]      echo_char;
      logic                   tail;
      logic [BYTE_W-1:0]      tail_char;
      logic [KEY_WORDS_W-1:0] key_words;
      logic                   key_overflow;
   } op_type;

endpackage

>>> hdl/bcpd_channels.sv
// valid/ready channel interfaces for requests and responses
// depends on bcpd_pkg
interface bcpd_req_chan;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic [bcpd_pkg::BYTE_W-1:0]   data_byte;
   logic                          end_of_text;

   modport source (output valid, req_type, data_byte, end_of_text, input ready);
   modport sink   (input valid, req_type, data_byte, end_of_text, output ready);
endinterface

interface bcpd_rsp_chan;
   logic                             valid;
   logic                             ready;
   logic [bcpd_pkg::BYTE_W-1:0]      out_char;
   logic                             from_key;
   logic                             out_of_range;
   logic                             end_of_message;
   logic [bcpd_pkg::KEY_WORDS_W-1:0] key_words;
   logic                             key_overflow;

   modport source (output valid, out_char, from_key, out_of_range, end_of_message,
                   key_words, key_overflow, input ready);
   modport sink   (input valid, out_char, from_key, out_of_range, end_of_message,
                   key_words, key_overflow, output ready);
endinterface

>>> hdl/bcpd_front.sv
// front end: takes requests, tracks key fill state and the pair parser, emits ops
// depends on bcpd_pkg, bcpd_channels and the assertion macro header
`include "book_cipher_position_decoder_macros.svh"

module bcpd_front #(
   parameter int MAX_WORDS       = 4096,
   parameter int KEY_STORE_CHARS = 32768,
   parameter int MAX_WORD_LEN    = 128
) (
   input  logic              clock,
   input  logic              reset,
   bcpd_req_chan.sink        req_if,
   output logic              op_valid,
   output bcpd_pkg::op_type  op,
   input  logic              op_ready
);

   localparam int CNT_W   = $clog2(MAX_WORDS + 1);
   localparam int FILL_W  = $clog2(KEY_STORE_CHARS + 1);
   localparam int KADDR_W = $clog2(KEY_STORE_CHARS);
   localparam int ACC_W   = bcpd_pkg::ACC_W;
   localparam int LEN_W   = bcpd_pkg::LEN_W;

   localparam logic [CNT_W-1:0]  WORDS_LIMIT = CNT_W'(MAX_WORDS);
   localparam logic [FILL_W-1:0] FILL_LIMIT  = FILL_W'(KEY_STORE_CHARS);
   localparam logic [LEN_W-1:0]  LEN_LIMIT   = LEN_W'(MAX_WORD_LEN);
   localparam logic [7:0]        CASE_OFFSET = 8'd32;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WORD = 2'd1;
   localparam logic [1:0] PH_CHAR = 2'd2;

   function automatic logic [bcpd_pkg::ACC_W-1:0] acc_step(
      input logic [bcpd_pkg::ACC_W-1:0] acc,
      input logic [3:0]                 d
   );
      logic [bcpd_pkg::ACC_W+3:0] v;
      v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (bcpd_pkg::ACC_W+4)'(d);
      return (v > (bcpd_pkg::ACC_W+4)'(bcpd_pkg::ACC_MAX)) ? bcpd_pkg::ACC_MAX
                                                           : v[bcpd_pkg::ACC_W-1:0];
   endfunction

   logic [CNT_W-1:0]   stored_ff, stored_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [KADDR_W-1:0] start_ff, start_in;
   logic               open_ff, open_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic [1:0]         phase_ff, phase_in;
   logic [ACC_W-1:0]   wacc_ff, wacc_in;
   logic [ACC_W-1:0]   cacc_ff, cacc_in;

   logic       accept;
   logic       work;
   logic       pass_idle;
   logic [7:0] b;
   logic [7:0] dsub;
   logic       is_digit;
   logic       is_sep;

   assign req_if.ready = op_ready;
   assign accept       = req_if.valid && op_ready;
   assign b            = req_if.data_byte;
   assign dsub         = b - bcpd_pkg::CH_ZERO;
   assign is_digit     = (b >= bcpd_pkg::CH_ZERO) && (b <= bcpd_pkg::CH_NINE);
   assign is_sep       = (b == bcpd_pkg::CH_SPACE) || (b == bcpd_pkg::CH_TAB) ||
                         (b == bcpd_pkg::CH_NL);
   assign op_valid     = accept && work;

   always_comb begin
      stored_in = stored_ff;
      fill_in   = fill_ff;
      start_in  = start_ff;
      open_in   = open_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      phase_in  = phase_ff;
      wacc_in   = wacc_ff;
      cacc_in   = cacc_ff;
      pass_idle = 1'b0;
      work      = 1'b0;
      op        = '0;
      if (accept) begin
         unique case (req_if.req_type)
            bcpd_pkg::REQ_CLEAR: begin
               stored_in = '0;
               fill_in   = '0;
               open_in   = 1'b0;
               len_in    = '0;
               ovf_in    = 1'b0;
            end
            bcpd_pkg::REQ_KEY: begin
               if (!ovf_ff) begin
                  if (is_sep) begin
                     if (open_ff) begin
                        op.wr_len  = 1'b1;
                        op.wr_idx  = bcpd_pkg::IDX_MAX_W'(stored_ff);
                        op.len_val = len_ff;
                        stored_in  = stored_ff + 1'b1;
                        open_in    = 1'b0;
                        len_in     = '0;
                     end
                  end else if (!open_ff && ((stored_ff >= WORDS_LIMIT) ||
                                            (fill_ff >= FILL_LIMIT))) begin
                     ovf_in = 1'b1;
                  end else if (open_ff && ((len_ff >= LEN_LIMIT) ||
                                           (fill_ff >= FILL_LIMIT))) begin
                     // partial word is dropped and the fill point rewinds
                     ovf_in  = 1'b1;
                     fill_in = FILL_W'(start_ff);
                     open_in = 1'b0;
                     len_in  = '0;
                  end else begin
                     if (!open_ff) begin
                        op.wr_start  = 1'b1;
                        op.wr_idx    = bcpd_pkg::IDX_MAX_W'(stored_ff);
                        op.start_val = bcpd_pkg::ADDR_MAX_W'(fill_ff);
                        start_in     = fill_ff[KADDR_W-1:0];
                     end
                     op.wr_char   = 1'b1;
                     op.char_addr = bcpd_pkg::ADDR_MAX_W'(fill_ff);
                     op.char_val  = ((b >= bcpd_pkg::CH_UP_A) && (b <= bcpd_pkg::CH_UP_Z)) ?
                                    b + CASE_OFFSET : b;
                     fill_in      = fill_ff + 1'b1;
                     open_in      = 1'b1;
                     len_in       = (open_ff ? len_ff : '0) + 1'b1;
                  end
               end
               if (req_if.end_of_text) begin
                  if (open_in) begin
                     op.wr_len  = 1'b1;
                     op.wr_idx  = bcpd_pkg::IDX_MAX_W'(stored_ff);
                     op.len_val = len_in;
                     stored_in  = stored_ff + 1'b1;
                     open_in    = 1'b0;
                     len_in     = '0;
                  end
                  op.tail      = 1'b1;
                  op.tail_char = bcpd_pkg::CH_NUL;
               end
               work = op.wr_start || op.wr_len || op.wr_char || op.tail;
            end
            bcpd_pkg::REQ_CIPHER: begin
               unique case (phase_ff)
                  PH_WORD: begin
                     if (is_digit) begin
                        wacc_in = acc_step(wacc_ff, dsub[3:0]);
                     end else if (b == bcpd_pkg::CH_COMMA) begin
                        phase_in = PH_CHAR;
                        cacc_in  = '0;
                     end else begin
                        op.lookup   = 1'b1;
                        op.word_idx = wacc_ff;
                        op.char_idx = '0;
                        cacc_in     = '0;
                        phase_in    = PH_IDLE;
                        pass_idle   = 1'b1;
                     end
                  end
                  PH_CHAR: begin
                     if (is_digit) begin
                        cacc_in = acc_step(cacc_ff, dsub[3:0]);
                     end else begin
                        op.lookup   = 1'b1;
                        op.word_idx = wacc_ff;
                        op.char_idx = cacc_ff;
                        phase_in    = PH_IDLE;
                        pass_idle   = 1'b1;
                     end
                  end
                  default: begin
                     phase_in  = PH_IDLE;
                     pass_idle = 1'b1;
                  end
               endcase
               // the byte that ends a pair is handled again as an idle byte
               if (pass_idle) begin
                  if ((b == bcpd_pkg::CH_SPACE) || (b == bcpd_pkg::CH_HASH)) begin
                     op.echo      = 1'b1;
                     op.echo_char = b;
                  end else if (is_digit) begin
                     phase_in = PH_WORD;
                     wacc_in  = ACC_W'(dsub[3:0]);
                     cacc_in  = '0;
                  end
               end
               if (req_if.end_of_text) begin
                  if (phase_in != PH_IDLE) begin
                     op.lookup   = 1'b1;
                     op.word_idx = wacc_in;
                     op.char_idx = cacc_in;
                     phase_in    = PH_IDLE;
                  end
                  op.tail      = 1'b1;
                  op.tail_char = bcpd_pkg::CH_NL;
               end
               op.in_range = (ACC_W+1)'(op.word_idx) < (ACC_W+1)'(stored_ff);
               work        = op.lookup || op.echo || op.tail;
            end
            default: ;
         endcase
      end
      op.key_words    = bcpd_pkg::KEY_WORDS_W'(stored_in);
      op.key_overflow = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         fill_ff   <= '0;
         open_ff   <= 1'b0;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         phase_ff  <= PH_IDLE;
         wacc_ff   <= '0;
         cacc_ff   <= '0;
      end else begin
         stored_ff <= stored_in;
         fill_ff   <= fill_in;
         open_ff   <= open_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         phase_ff  <= phase_in;
         wacc_ff   <= wacc_in;
         cacc_ff   <= cacc_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   `BCPD_ASSERT_IMPLY(a_open_not_overflowed, clock, reset, open_ff, !ovf_ff)
   `BCPD_ASSERT_ALWAYS(a_word_count_bound, clock, reset, stored_ff <= WORDS_LIMIT)

endmodule

>>> hdl/bcpd_queue.sv
// short op queue between the front end and the back end
// depends on bcpd_pkg and the assertion macro header
`include "book_cipher_position_decoder_macros.svh"

module bcpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  bcpd_pkg::op_type  in_op,
   output logic              in_ready,
   output logic              out_valid,
   output bcpd_pkg::op_type  out_op,
   input  logic              out_ready
);

   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam logic [PTR_W:0] COUNT_FULL = (PTR_W+1)'(QDEPTH);

   bcpd_pkg::op_type slot_ff [QDEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != COUNT_FULL;
   assign out_valid = count_ff != '0;
   assign out_op    = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_op;
      end
   end

   `BCPD_ASSERT_ALWAYS(a_queue_count_bound, clock, reset, count_ff <= COUNT_FULL)

endmodule

>>> hdl/bcpd_back.sv
// back end: key store memories, pair lookup and the registered result stage
// depends on bcpd_pkg, bcpd_channels and the assertion macro header
`include "book_cipher_position_decoder_macros.svh"

module bcpd_back #(
   parameter int MAX_WORDS       = 4096,
   parameter int KEY_STORE_CHARS = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   input  bcpd_pkg::op_type  op,
   output logic              op_ready,
   bcpd_rsp_chan.source      rsp_if
);

   localparam int WIDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int KADDR_W = $clog2(KEY_STORE_CHARS);
   localparam int LEN_W   = bcpd_pkg::LEN_W;
   localparam int BYTE_W  = bcpd_pkg::BYTE_W;
   localparam int ACC_W   = bcpd_pkg::ACC_W;

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_WORD = 2'd1;
   localparam logic [1:0] P_EMIT = 2'd2;

   localparam int SLOT_LOOKUP = 0;
   localparam int SLOT_ECHO   = 1;

   logic [KADDR_W-1:0] start_mem [MAX_WORDS];
   logic [LEN_W-1:0]   len_mem   [MAX_WORDS];
   logic [BYTE_W-1:0]  char_mem  [KEY_STORE_CHARS];

   logic [1:0]        phase_ff, phase_in;
   logic [2:0]        pend_ff, pend_in;
   logic              hit_ff, hit_in;
   bcpd_pkg::op_type  cur_ff, cur_in;

   logic [KADDR_W-1:0] start_rd_ff;
   logic [LEN_W-1:0]   len_rd_ff;
   logic [BYTE_W-1:0]  char_rd_ff;
   logic [KADDR_W-1:0] char_rd_addr;

   logic                             out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]                out_char_ff, out_char_in;
   logic                             from_key_ff, from_key_in;
   logic                             oor_ff, oor_in;
   logic                             eom_ff, eom_in;
   logic [bcpd_pkg::KEY_WORDS_W-1:0] kw_ff, kw_in;
   logic                             kovf_ff, kovf_in;

   logic       out_free;
   logic       can_pop;
   logic       pop;
   logic       rd_word;
   logic [2:0] emit_slot;

   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign rd_word      = pop && op.lookup && op.in_range;
   assign char_rd_addr = start_rd_ff + KADDR_W'(cur_ff.char_idx);

   always_comb begin
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      hit_in       = hit_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_char_in  = out_char_ff;
      from_key_in  = from_key_ff;
      oor_in       = oor_ff;
      eom_in       = eom_ff;
      kw_in        = kw_ff;
      kovf_in      = kovf_ff;
      emit_slot    = '0;
      can_pop      = 1'b0;
      unique case (phase_ff)
         P_WORD: begin
            hit_in   = ACC_W'(len_rd_ff) > cur_ff.char_idx;
            phase_in = P_EMIT;
         end
         P_EMIT: begin
            if (out_free) begin
               // lowest pending slot goes first: lookup, then echo, then tail
               emit_slot = pend_ff & (~pend_ff + 3'd1);
               pend_in   = pend_ff & ~emit_slot;
               if (pend_in == '0) begin
                  phase_in = P_IDLE;
                  can_pop  = 1'b1;
               end
            end
         end
         default: can_pop = 1'b1;
      endcase

      if (emit_slot != '0) begin
         out_valid_in = 1'b1;
         kw_in        = cur_ff.key_words;
         kovf_in      = cur_ff.key_overflow;
         priority if (emit_slot[SLOT_LOOKUP]) begin
            out_char_in = hit_ff ? char_rd_ff : bcpd_pkg::CH_HASH;
            from_key_in = hit_ff;
            oor_in      = !hit_ff;
            eom_in      = 1'b0;
         end else if (emit_slot[SLOT_ECHO]) begin
            out_char_in = cur_ff.echo_char;
            from_key_in = 1'b0;
            oor_in      = 1'b0;
            eom_in      = 1'b0;
         end else begin
            out_char_in = cur_ff.tail_char;
            from_key_in = 1'b0;
            oor_in      = 1'b0;
            eom_in      = 1'b1;
         end
      end

      op_ready = can_pop;
      pop      = can_pop && op_valid;
      if (pop) begin
         cur_in  = op;
         hit_in  = 1'b0;
         pend_in = {op.tail, op.echo, op.lookup};
         if (op.lookup && op.in_range) begin
            phase_in = P_WORD;
         end else if (op.lookup || op.echo || op.tail) begin
            phase_in = P_EMIT;
         end else begin
            phase_in = P_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_IDLE;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      cur_ff      <= cur_in;
      out_char_ff <= out_char_in;
      from_key_ff <= from_key_in;
      oor_ff      <= oor_in;
      eom_ff      <= eom_in;
      kw_ff       <= kw_in;
      kovf_ff     <= kovf_in;
   end

   // word table: written on key ops, read when a pair is taken
   always_ff @(posedge clock) begin
      if (pop && op.wr_start) begin
         start_mem[op.wr_idx[WIDX_W-1:0]] <= op.start_val[KADDR_W-1:0];
      end
      if (rd_word) begin
         start_rd_ff <= start_mem[op.word_idx[WIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (pop && op.wr_len) begin
         len_mem[op.wr_idx[WIDX_W-1:0]] <= op.len_val;
      end
      if (rd_word) begin
         len_rd_ff <= len_mem[op.word_idx[WIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (pop && op.wr_char) begin
         char_mem[op.char_addr[KADDR_W-1:0]] <= op.char_val;
      end
      if (phase_ff == P_WORD) begin
         char_rd_ff <= char_mem[char_rd_addr];
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.out_char       = out_char_ff;
   assign rsp_if.from_key       = from_key_ff;
   assign rsp_if.out_of_range   = oor_ff;
   assign rsp_if.end_of_message = eom_ff;
   assign rsp_if.key_words      = kw_ff;
   assign rsp_if.key_overflow   = kovf_ff;

   `BCPD_ASSERT_NEXT(a_word_read_then_check, clock, reset, rd_word, phase_ff == P_WORD)
   `BCPD_ASSERT_IMPLY(a_emit_has_work, clock, reset, phase_ff == P_EMIT, pend_ff != 3'b000)
   `BCPD_ASSERT_IMPLY(a_flags_exclusive, clock, reset, out_valid_ff, !(from_key_ff && oor_ff))

endmodule

>>> hdl/book_cipher_position_decoder.sv
// book cipher position decoder top level; depends on bcpd_pkg, bcpd_channels and its parts
// a request is in the op queue at its accept edge; an echo, newline, key report or
// '#' goes through the back end op register and output register to rsp, a lookup of a stored
// word also through the word table, then the key store read; one request a cycle while the
// four-entry queue has room; the back end takes a new op when the last op's results are out
// reset: synchronous; clears key counts, parser, queue and back end phase; key memories stay
module book_cipher_position_decoder #(
   parameter int MAX_WORDS       = 4096,
   parameter int KEY_STORE_CHARS = 32768,
   parameter int MAX_WORD_LEN    = 128
) (
   input  logic          clock,
   input  logic          reset,
   bcpd_req_chan.sink    req_if,
   bcpd_rsp_chan.source  rsp_if
);

   logic             push_valid;
   logic             push_ready;
   bcpd_pkg::op_type push_op;
   logic             head_valid;
   logic             head_ready;
   bcpd_pkg::op_type head_op;

   bcpd_front #(
      .MAX_WORDS       (MAX_WORDS),
      .KEY_STORE_CHARS (KEY_STORE_CHARS),
      .MAX_WORD_LEN    (MAX_WORD_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .op_valid (push_valid),
      .op       (push_op),
      .op_ready (push_ready)
   );

   bcpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_op     (push_op),
      .in_ready  (push_ready),
      .out_valid (head_valid),
      .out_op    (head_op),
      .out_ready (head_ready)
   );

   bcpd_back #(
      .MAX_WORDS       (MAX_WORDS),
      .KEY_STORE_CHARS (KEY_STORE_CHARS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (head_valid),
      .op       (head_op),
      .op_ready (head_ready),
      .rsp_if   (rsp_if)
   );

endmodule
